// ===== sv/aes_block_cipher_defines.svh =====
// Assertion macros shared by the AES block cipher RTL.
// No dependencies.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define AES_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
// next-cycle implication
`define AES_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`endif

// ===== sv/aes_pkg.sv =====
// Package for the AES block cipher: S-boxes, GF(2^8) helpers, control types.
// No dependencies.
`default_nettype none
package aes_pkg;
	localparam logic [1:0] KL_128 = 2'd0;
	localparam logic [1:0] KL_192 = 2'd1;
	localparam logic [1:0] KL_256 = 2'd2;
	localparam int unsigned REG_KEY_LENGTH = 0;
	localparam int unsigned REG_KEY_PART_0 = 1;
	localparam int unsigned REG_KEY_PART_3 = 4;

	// key schedule state handed to the cipher core
	typedef struct packed {
		logic       busy;
		logic [3:0] nr;
	} aes_ks_stat_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		sbox = t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
		inv_sbox = t[a];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction
endpackage
`default_nettype wire

// ===== sv/aes_key_sched.sv =====
// Key expansion sequencer: writes one schedule word per cycle into the
// round key memory owned by the cipher core. Uses aes_pkg.
`default_nettype none
module aes_key_sched #(
	parameter int unsigned WORDS = 60,
	parameter int unsigned AW    = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     key_length,
	input  wire logic [255:0]   key,
	output aes_pkg::aes_ks_stat_t stat,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [31:0]         wr_data
);
	import aes_pkg::*;
	`include "aes_block_cipher_defines.svh"

	logic [3:0]    nk_q;
	logic [AW:0]   idx_q;
	logic [AW:0]   total_q;
	logic [2:0]    pos_q;
	logic [7:0]    rc_q;
	logic [31:0]   hist_q [8];
	logic          busy_q;
	logic [3:0]    nk_sel;
	logic [31:0]   t_word;
	logic [31:0]   new_word;

	// use the requested key length, or the largest shorter one whose schedule fits the store
	always_comb begin
		nk_sel = (key_length == KL_128) ? 4'd4 : (key_length == KL_192) ? 4'd6 : 4'd8;
		if (nk_sel == 4'd8 && WORDS < 60) nk_sel = 4'd6;
		if (nk_sel == 4'd6 && WORDS < 52) nk_sel = 4'd4;
	end

	// next schedule word from the last nk words, or a key word for the first nk
	always_comb begin
		t_word = hist_q[0];
		if (pos_q == 3'd0)
			t_word = sub_word({hist_q[0][23:0], hist_q[0][31:24]}) ^ {rc_q, 24'd0};
		else if (nk_q == 4'd8 && pos_q == 3'd4)
			t_word = sub_word(hist_q[0]);
		new_word = hist_q[nk_q[2:0] - 3'd1] ^ t_word;
		if (idx_q < (AW+1)'(nk_q))
			new_word = key[255 - 32*idx_q[2:0] -: 32];
	end

	assign wr_en   = busy_q;
	assign wr_addr = idx_q[AW-1:0];
	assign wr_data = new_word;
	assign stat.busy = busy_q;
	assign stat.nr   = nk_q + 4'd6;

	// advance one word per cycle, shift history (hist_q[0] newest)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			nk_q   <= 4'd4;
			idx_q  <= '0;
			total_q <= '0;
			pos_q  <= '0;
			rc_q   <= 8'h01;
		end else if (start && !busy_q) begin
			busy_q  <= 1'b1;
			nk_q    <= nk_sel;
			idx_q   <= '0;
			pos_q   <= '0;
			rc_q    <= 8'h01;
			total_q <= (AW+1)'(4*(32'(nk_sel) + 7) > WORDS ? WORDS : 4*(32'(nk_sel) + 7));
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q >= (AW+1)'(nk_q)) begin
				if (pos_q == 3'd0) rc_q <= xt(rc_q);
			end
			pos_q <= (pos_q == nk_q[2:0] - 3'd1 || nk_q == 4'd8 && pos_q == 3'd7) ?
				3'd0 : pos_q + 3'd1;
			if (idx_q + 1'b1 == total_q) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			hist_q[0] <= new_word;
			for (int i = 1; i < 8; i++) hist_q[i] <= hist_q[i-1];
		end
	end

	`AES_ASSERT_IMP(a_ks_addr, clk, arst_n, busy_q, idx_q < total_q)
	`AES_ASSERT_IMP(a_ks_pos, clk, arst_n, busy_q, pos_q < nk_q[3:0])
	`AES_ASSERT_NXT(a_ks_start, clk, arst_n, start && !busy_q, busy_q && idx_q == '0)
endmodule
`default_nettype wire

// ===== sv/aes_core.sv =====
// Round-iterative cipher core with the round key memory; one round per
// cycle plus a round key prefetch. Uses aes_pkg.
`default_nettype none
module aes_core #(
	parameter int unsigned WORDS = 60,
	parameter int unsigned AW    = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           ks_wr_en,
	input  wire logic [AW-1:0]  ks_wr_addr,
	input  wire logic [31:0]    ks_wr_data,
	input  wire logic           start,
	input  wire logic [3:0]     nr,
	input  wire logic [127:0]   blk_in,
	input  wire logic           dec_in,
	output logic                busy,
	output logic                done,
	output logic [127:0]        blk_out
);
	import aes_pkg::*;
	`include "aes_block_cipher_defines.svh"

	// four banks, one per column, so a whole round key reads at once
	logic [31:0] mem0 [WORDS/4+1];
	logic [31:0] mem1 [WORDS/4+1];
	logic [31:0] mem2 [WORDS/4+1];
	logic [31:0] mem3 [WORDS/4+1];
	logic [127:0] rk_q;
	logic [127:0] st_q;
	logic [3:0]   rnd_q;
	logic [3:0]   nr_q;
	logic         dec_q;
	logic         run_q;
	logic         first_q;
	logic         done_q;
	logic [3:0]   rd_rnd;
	logic [127:0] fwd, inv, sub_s, nxt;

	always_ff @(posedge clk) begin
		if (ks_wr_en) begin
			case (ks_wr_addr[1:0])
				2'd0: mem0[ks_wr_addr[AW-1:2]] <= ks_wr_data;
				2'd1: mem1[ks_wr_addr[AW-1:2]] <= ks_wr_data;
				2'd2: mem2[ks_wr_addr[AW-1:2]] <= ks_wr_data;
				default: mem3[ks_wr_addr[AW-1:2]] <= ks_wr_data;
			endcase
		end
		rk_q <= {mem0[rd_rnd], mem1[rd_rnd], mem2[rd_rnd], mem3[rd_rnd]};
	end

	// round key address for the next cycle; an inverse round r uses key r-1
	always_comb begin
		if (!run_q) rd_rnd = dec_in ? nr : 4'd0;
		else if (dec_q) rd_rnd = first_q ? rnd_q - 4'd1 : rnd_q - 4'd2;
		else rd_rnd = rnd_q + 4'd1;
	end

	function automatic logic [7:0] b(input logic [127:0] s, input int i);
		b = s[127 - 8*i -: 8];
	endfunction

	// one forward and one inverse round on the current state
	always_comb begin
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sub_s[127 - 8*(4*c+r) -: 8] = sbox(b(st_q, 4*((c + r) & 3) + r));
			end
		end
		fwd = sub_s;
		for (int c = 0; c < 4; c++) begin
			a0 = b(sub_s, 4*c); a1 = b(sub_s, 4*c+1); a2 = b(sub_s, 4*c+2); a3 = b(sub_s, 4*c+3);
			if (rnd_q != nr_q) begin
				fwd[127-32*c -: 32] = {xt(a0)^xt(a1)^a1^a2^a3, a0^xt(a1)^xt(a2)^a2^a3,
					a0^a1^xt(a2)^xt(a3)^a3, xt(a0)^a0^a1^a2^xt(a3)};
			end
		end
		fwd = fwd ^ rk_q;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				inv[127 - 8*(4*c+r) -: 8] = inv_sbox(b(st_q, 4*((c - r + 4) & 3) + r));
			end
		end
		inv = inv ^ rk_q;
		if (rnd_q != 4'd1) begin
			for (int c = 0; c < 4; c++) begin
				logic [7:0] x [4];
				logic [7:0] y [4];
				for (int k = 0; k < 4; k++) x[k] = b(inv, 4*c+k);
				for (int r = 0; r < 4; r++) begin
					y[r] = 8'h00;
					for (int k = 0; k < 4; k++) begin
						logic [7:0] m2, m4, m8;
						m2 = xt(x[k]); m4 = xt(m2); m8 = xt(m4);
						case ((k - r + 4) & 3)
							0: y[r] = y[r] ^ m8 ^ m4 ^ m2;
							1: y[r] = y[r] ^ m8 ^ m2 ^ x[k];
							2: y[r] = y[r] ^ m8 ^ m4 ^ x[k];
							default: y[r] = y[r] ^ m8 ^ x[k];
						endcase
					end
				end
				inv[127-32*c -: 32] = {y[0], y[1], y[2], y[3]};
			end
		end
		nxt = first_q ? (st_q ^ rk_q) : (dec_q ? inv : fwd);
	end

	// step rounds; state holds the block, first cycle adds the initial key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			first_q <= 1'b0;
			rnd_q <= '0;
			nr_q <= 4'd10;
			dec_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !run_q) begin
				run_q <= 1'b1;
				first_q <= 1'b1;
				nr_q <= nr;
				dec_q <= dec_in;
				rnd_q <= dec_in ? nr : 4'd0;
			end else if (run_q) begin
				first_q <= 1'b0;
				if (first_q) begin
					rnd_q <= dec_q ? rnd_q : 4'd1;
				end else if (dec_q ? rnd_q == 4'd1 : rnd_q == nr_q) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !run_q) st_q <= blk_in;
		else if (run_q) st_q <= nxt;
	end

	assign busy = run_q;
	assign done = done_q;
	assign blk_out = st_q;

	`AES_ASSERT_IMP(a_core_rnd, clk, arst_n, run_q, rnd_q <= nr_q)
	`AES_ASSERT_NXT(a_core_done, clk, arst_n, done_q, !run_q)
	`AES_ASSERT_IMP(a_core_nr, clk, arst_n, run_q, nr_q == 4'd10 || nr_q == 4'd12 || nr_q == 4'd14)
endmodule
`default_nettype wire

// ===== sv/aes_block_cipher.sv =====
// Top level of the AES block cipher: registers, handshake, output buffer.
// Instantiates aes_key_sched and aes_core; uses aes_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  in       | in_valid / in_ready   | block_high, block_low, decrypt
//  out      | out_valid / out_ready | result_high, result_low
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// A block takes one initial key addition, then one round per cycle, with
// each round key registered from the banked memory ahead of its round. After
// reset or a write to the key length or key registers the first block waits
// for key expansion, one word per cycle (44, 52 or 60 words). The result
// register frees the core, so a next block starts while a result waits.
`default_nettype none
module aes_block_cipher #(
	parameter int unsigned SCHEDULE_WORDS = 60
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] block_high,
	input  wire logic [63:0] block_low,
	input  wire logic        decrypt,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result_high,
	output logic [63:0]      result_low
);
	import aes_pkg::*;
	`include "aes_block_cipher_defines.svh"

	localparam int unsigned AW = $clog2(SCHEDULE_WORDS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEYS = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_HOLD = 4'b1000
	} st_t;

	st_t           st_q;
	logic [1:0]    klen_q;
	logic [255:0]  key_q;
	logic          ready_q;
	logic [127:0]  blk_q;
	logic          dec_q;
	logic          out_v_q;
	logic [127:0]  res_q;
	aes_ks_stat_t  ks_stat;
	logic          ks_start;
	logic          ks_we;
	logic [AW-1:0] ks_addr;
	logic [31:0]   ks_data;
	logic          core_start, core_busy, core_done;
	logic [127:0]  core_out;
	logic          in_fire;

	aes_key_sched #(.WORDS(SCHEDULE_WORDS), .AW(AW)) u_ks (
		.clk, .arst_n, .start(ks_start), .key_length(klen_q), .key(key_q),
		.stat(ks_stat), .wr_en(ks_we), .wr_addr(ks_addr), .wr_data(ks_data)
	);

	aes_core #(.WORDS(SCHEDULE_WORDS), .AW(AW)) u_core (
		.clk, .arst_n, .ks_wr_en(ks_we), .ks_wr_addr(ks_addr), .ks_wr_data(ks_data),
		.start(core_start), .nr(ks_stat.nr), .blk_in(blk_q), .dec_in(dec_q),
		.busy(core_busy), .done(core_done), .blk_out(core_out)
	);

	assign in_ready = (st_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign ks_start = (st_q == ST_KEYS) && !ks_stat.busy && !ready_q;
	assign core_start = (st_q == ST_KEYS) && ready_q && !ks_stat.busy;

	// register writes; key length and key writes drop the schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KL_128;
			key_q <= '0;
		end else if (cfg_we) begin
			if (32'(cfg_index) == REG_KEY_LENGTH) klen_q <= cfg_data[1:0];
			else if (32'(cfg_index) <= REG_KEY_PART_3)
				key_q[255 - 64*(cfg_index - 3'd1) -: 64] <= cfg_data;
		end
	end

	// sequence: accept, expand if needed, run, hold until output slot free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ready_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_v_q <= 1'b0;
			if (cfg_we && 32'(cfg_index) <= REG_KEY_PART_3) ready_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_fire) st_q <= ST_KEYS;
				ST_KEYS: begin
					if (ks_start) ready_q <= 1'b1;
					if (core_start) st_q <= ST_RUN;
				end
				ST_RUN: if (core_done) st_q <= ST_HOLD;
				ST_HOLD: if (!out_v_q || out_ready) begin
					out_v_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			blk_q <= {block_high, block_low};
			dec_q <= decrypt;
		end
		if (st_q == ST_HOLD && (!out_v_q || out_ready)) res_q <= core_out;
	end

	assign out_valid   = out_v_q;
	assign result_high = res_q[127:64];
	assign result_low  = res_q[63:0];

	`AES_ASSERT_IMP(a_top_core, clk, arst_n, core_busy, st_q == ST_RUN)
	`AES_ASSERT_IMP(a_top_ks, clk, arst_n, ks_stat.busy, st_q == ST_KEYS)
	`AES_ASSERT_NXT(a_top_done, clk, arst_n, core_done, st_q == ST_HOLD)
endmodule
`default_nettype wire

// ===== test/aes_block_cipher_test.sv =====
// Self-checking testbench for the AES block cipher: encrypts and decrypts
// blocks under every key length and compares each result with a predictor.
// Depends on aes_pkg (key length and register codes) and aes_block_cipher.
`timescale 1ns / 100ps
module aes_block_cipher_test;
	import aes_pkg::*;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        dec;
	} block_beat_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_out_t;

	localparam int unsigned KEY_WORDS_MAX = 60;
	localparam int unsigned REG_KEY_PART_1 = 2;
	localparam int unsigned REG_KEY_PART_2 = 3;
	localparam int unsigned CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        decrypt;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_high;
	logic [63:0] result_low;

	aes_block_cipher DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.block_high(block_high), .block_low(block_low), .decrypt(decrypt),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_high(result_high), .result_low(result_low)
	);

	// predictor state: key registers and the expanded schedule
	logic [1:0]  key_len_reg;
	logic [63:0] key_reg [4];
	logic [31:0] round_keys [KEY_WORDS_MAX];
	bit          keys_expanded;
	int unsigned key_nk;

	block_beat_t pending_blocks[$];
	cipher_out_t expected_blocks[$];
	int unsigned error_count;
	int unsigned cycle_count;
	bit          stimulus_done;
	bit          in_accepted;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// S-box tables built locally from GF(2^8) multiplicative inverses and the affine map
	logic [7:0] fwd_sbox [256];
	logic [7:0] rev_sbox [256];

	function automatic logic [7:0] gf_double(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = gf_double(a);
		end
		return acc;
	endfunction

	task automatic build_sboxes();
		logic [7:0] inv;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gf_mult(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_sbox[x] = s;
			rev_sbox[s] = x[7:0];
		end
	endtask

	function automatic logic [31:0] sub_key_word(logic [31:0] w);
		return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]],
			fwd_sbox[w[7:0]]};
	endfunction

	task automatic expand_round_keys();
		int unsigned total;
		logic [31:0] t;
		logic [7:0]  rcon;
		key_nk = (key_len_reg >= KL_256) ? 8 : (key_len_reg == KL_192 ? 6 : 4);
		while (key_nk > 4 && 4 * (key_nk + 7) > KEY_WORDS_MAX)
			key_nk -= 2;
		total = 4 * (key_nk + 7);
		rcon = 8'h01;
		for (int i = 0; i < key_nk; i++)
			round_keys[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
		for (int i = key_nk; i < total; i++) begin
			t = round_keys[i - 1];
			if (i % key_nk == 0) begin
				t = sub_key_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
				rcon = gf_double(rcon);
			end else if (key_nk > 6 && i % key_nk == 4) begin
				t = sub_key_word(t);
			end
			round_keys[i] = round_keys[i - key_nk] ^ t;
		end
		keys_expanded = 1'b1;
	endtask

	function automatic void xor_round_key(ref logic [7:0] s [16], input int rnd);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				s[4 * c + r] ^= round_keys[4 * rnd + c][31 - 8 * r -: 8];
	endfunction

	function automatic void rotate_rows(ref logic [7:0] s [16], input int dir);
		logic [7:0] t [16];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[4 * c + r] = s[4 * ((c + dir * r + 8) & 3) + r];
		s = t;
	endfunction

	function automatic void mix_state(ref logic [7:0] s [16], input bit inverse);
		logic [7:0] t [16];
		logic [7:0] m [4];
		logic [7:0] acc;
		if (inverse)
			m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else
			m = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++)
					acc ^= gf_mult(s[4 * c + k], m[(k - r + 4) & 3]);
				t[4 * c + r] = acc;
			end
		s = t;
	endfunction

	task automatic predict_cipher(input block_beat_t b, output cipher_out_t res);
		logic [7:0] s [16];
		int nr;
		if (!keys_expanded)
			expand_round_keys();
		nr = key_nk + 6;
		for (int i = 0; i < 8; i++) begin
			s[i] = b.hi[63 - 8 * i -: 8];
			s[8 + i] = b.lo[63 - 8 * i -: 8];
		end
		if (!b.dec) begin
			xor_round_key(s, 0);
			for (int r = 1; r <= nr; r++) begin
				for (int i = 0; i < 16; i++)
					s[i] = fwd_sbox[s[i]];
				rotate_rows(s, 1);
				if (r != nr)
					mix_state(s, 1'b0);
				xor_round_key(s, r);
			end
		end else begin
			xor_round_key(s, nr);
			for (int r = nr; r >= 1; r--) begin
				rotate_rows(s, -1);
				for (int i = 0; i < 16; i++)
					s[i] = rev_sbox[s[i]];
				xor_round_key(s, r - 1);
				if (r != 1)
					mix_state(s, 1'b1);
			end
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63 - 8 * i -: 8] = s[i];
			res.lo[63 - 8 * i -: 8] = s[8 + i];
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// drive a register write on the falling edge, mirror it in the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_LENGTH)
			key_len_reg = value[1:0];
		else if (idx <= REG_KEY_PART_3)
			key_reg[idx - REG_KEY_PART_0] = value;
		else
			return;
		keys_expanded = 1'b0;
	endtask

	// wait for all queued blocks to drain before touching registers
	task automatic drain();
		while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] edge64();
		case ($urandom_range(0, 3))
			0: return 64'h0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo,
			input logic dec);
		block_beat_t b;
		b.hi = hi;
		b.lo = lo;
		b.dec = dec;
		pending_blocks.push_back(b);
	endtask

	// driver: hold each beat until accepted, random gap between beats
	int unsigned in_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (in_valid && !in_accepted) begin
			// hold
		end else if (in_gap != 0 || pending_blocks.size() == 0) begin
			in_valid <= 1'b0;
			if (in_gap != 0)
				in_gap <= in_gap - 1;
		end else begin
			in_valid <= 1'b1;
			block_high <= pending_blocks[0].hi;
			block_low <= pending_blocks[0].lo;
			decrypt <= pending_blocks[0].dec;
			void'(pending_blocks.pop_front());
			in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		end
	end

	// predict each accepted beat
	always @(posedge clk) begin
		cipher_out_t res;
		block_beat_t b;
		in_accepted <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			b.hi = block_high;
			b.lo = block_low;
			b.dec = decrypt;
			predict_cipher(b, res);
			expected_blocks.push_back(res);
		end
	end

	// monitor: random stalls on the result side, check each result beat
	int unsigned out_stall;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else if (out_stall != 0) begin
			out_ready <= 1'b0;
			out_stall <= out_stall - 1;
		end else begin
			out_ready <= 1'b1;
			if (out_valid)
				out_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		end
	end

	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_blocks.size() == 0) begin
				$display("unexpected result beat %h %h at %0t", result_high,
					result_low, $realtime);
				error_count++;
			end else begin
				want = expected_blocks.pop_front();
				if (result_high !== want.hi)
					report_mismatch("result_high", result_high, want.hi);
				if (result_low !== want.lo)
					report_mismatch("result_low", result_low, want.lo);
			end
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL aes_block_cipher");
			$finish;
		end
	end

	initial begin
		logic [1:0] lens [6];
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		block_high = '0;
		block_low = '0;
		decrypt = 1'b0;
		in_valid = 1'b0;
		in_accepted = 1'b0;
		out_ready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		stimulus_done = 1'b0;
		key_len_reg = KL_128;
		foreach (key_reg[i])
			key_reg[i] = '0;
		keys_expanded = 1'b0;
		build_sboxes();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset key, then the standard example vectors
		queue_block(64'h0, 64'h0, 1'b0);
		queue_block('1, '1, 1'b1);
		drain();
		write_reg(REG_KEY_PART_0, 64'h0001020304050607);
		write_reg(REG_KEY_PART_1, 64'h08090a0b0c0d0e0f);
		write_reg(REG_KEY_PART_2, 64'h1011121314151617);
		write_reg(REG_KEY_PART_3, 64'h18191a1b1c1d1e1f);
		lens = '{KL_128, KL_192, KL_256, 2'd3, KL_128, KL_256};
		for (int l = 0; l < 4; l++) begin
			write_reg(REG_KEY_LENGTH, {62'd0, lens[l]});
			queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
			queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
			queue_block('1, 64'h0, 1'b0);
			queue_block(64'h0, '1, 1'b1);
			drain();
		end
		// out-of-range index is ignored
		write_reg(3'd5, rand64());
		write_reg(3'd7, '1);
		queue_block(rand64(), rand64(), 1'b0);
		drain();
		write_reg(REG_KEY_PART_0, '1);
		write_reg(REG_KEY_PART_3, '1);
		queue_block(64'h0, 64'h0, 1'b0);
		drain();

		// random phases, each with a fresh length and randomly chosen key parts rewritten
		for (int p = 0; p < 30; p++) begin
			write_reg(REG_KEY_LENGTH, {62'd0, 2'($urandom_range(0, 3))});
			for (int k = REG_KEY_PART_0; k <= REG_KEY_PART_3; k++)
				if ($urandom_range(0, 2) != 0)
					write_reg(k[2:0], edge64());
			for (int i = 0; i < 64; i++)
				queue_block(($urandom_range(0, 9) == 0) ? edge64() : rand64(),
					($urandom_range(0, 9) == 0) ? edge64() : rand64(),
					$urandom_range(0, 1));
			drain();
		end

		stimulus_done = 1'b1;
		if (error_count == 0)
			$display("PASS aes_block_cipher");
		else
			$display("FAIL aes_block_cipher");
		$finish;
	end
endmodule

// ===== aes_block_cipher.f =====
+incdir+sv
sv/aes_pkg.sv
sv/aes_key_sched.sv
sv/aes_core.sv
sv/aes_block_cipher.sv
test/aes_block_cipher_test.sv
